@@ hw/rtl/http_request_head_parser_assert.svh @@
// ----------------------------------------------------------------------------
// HTTP request head parser assertion macros
// Clocked assertion shorthands shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define HRHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define HRHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Parser states, byte roles, status codes and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [2:0] {
    ROLE_DELIM  = 3'd0,
    ROLE_METHOD = 3'd1,
    ROLE_URI    = 3'd2,
    ROLE_KEY    = 3'd3,
    ROLE_VALUE  = 3'd4
  } role_e;

  typedef enum logic [2:0] {
    STAT_BUSY    = 3'd0,
    STAT_ERROR   = 3'd1,
    STAT_LINE    = 3'd2,
    STAT_HEADER  = 3'd3,
    STAT_DONE    = 3'd4,
    STAT_IGNORED = 3'd5
  } status_e;

  typedef enum logic [21:0] {
    ST_METHOD     = 22'h000001,
    ST_URI_FIRST  = 22'h000002,
    ST_URI        = 22'h000004,
    ST_VER_H      = 22'h000008,
    ST_VER_T1     = 22'h000010,
    ST_VER_T2     = 22'h000020,
    ST_VER_P      = 22'h000040,
    ST_VER_SLASH  = 22'h000080,
    ST_VER_MAJOR  = 22'h000100,
    ST_VER_DOT    = 22'h000200,
    ST_VER_MINOR  = 22'h000400,
    ST_VER_CR     = 22'h000800,
    ST_RL_LF      = 22'h001000,
    ST_LINE_START = 22'h002000,
    ST_KEY        = 22'h004000,
    ST_COLON_SP   = 22'h008000,
    ST_VAL_FIRST  = 22'h010000,
    ST_VALUE      = 22'h020000,
    ST_HL_LF      = 22'h040000,
    ST_END_LF     = 22'h080000,
    ST_DONE       = 22'h100000,
    ST_ERROR      = 22'h200000
  } state_e;

  typedef struct packed {
    role_e       role;
    status_e     status;
    logic        minor;
    logic [15:0] offset;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/hrhp_if.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser channels
// Valid/ready interfaces for the byte input and the per-byte result.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_request;

  modport source (output valid, output data_byte, output new_request, input ready);
  modport sink   (input valid, input data_byte, input new_request, output ready);
endinterface

interface hrhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [2:0]  status;
  logic        http_minor;
  logic [15:0] byte_offset;

  modport source (output valid, output byte_role, output status, output http_minor,
                  output byte_offset, input ready);
  modport sink   (input valid, input byte_role, input status, input http_minor,
                  input byte_offset, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/http_request_head_parser.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser
// Byte-serial parser for the request line and header lines of HTTP/1.x.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Request payload                          | Handshake
//  --------+-----+------------------------------------------+-------------
//  req_i   | in  | data_byte[7:0], new_request              | valid/ready
//  res_o   | out | byte_role[2:0], status[2:0],             | valid/ready
//          |     | http_minor, byte_offset[15:0]            |
//
// One request is accepted per cycle while req_i is ready; its result is
// registered. The per-byte parser state update is a single combinational
// pass from the parser registers to the result register.
// A two-entry output buffer (result register plus skid register) keeps
// req_i ready while one finished result waits; req_i drops ready only when
// both entries are full.
// Reset returns the parser to the method state with zero offset and minor
// version, and empties the output buffer.
//
`default_nettype none

`include "http_request_head_parser_assert.svh"

module http_request_head_parser
  import hrhp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  hrhp_in_if.sink      req_i,
  hrhp_out_if.source   res_o
);

  localparam logic [OFFSET_BITS-1:0] OffsetMax = {OFFSET_BITS{1'b1}};

  // Parser state.
  state_e                 state_q, state_d;
  logic                   minor_q, minor_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;

  // Output buffer.
  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;
  result_t res_d;

  logic acc, take, out_load, skid_load;

  // Values seen by this byte: a new request restarts from the reset values.
  state_e                 state_cur;
  logic                   minor_cur;
  logic [OFFSET_BITS-1:0] offset_cur;
  logic [31:0]            offset_wide;
  logic [7:0]             b;
  role_e                  role;
  status_e                status;

  assign req_i.ready = !skid_vld_q;
  assign acc         = req_i.valid && req_i.ready;
  assign take        = out_vld_q && res_o.ready;
  assign out_load    = acc && (!out_vld_q || take);
  assign skid_load   = acc && out_vld_q && !take;

  assign b          = req_i.data_byte;
  assign state_cur  = req_i.new_request ? ST_METHOD : state_q;
  assign minor_cur  = req_i.new_request ? 1'b0 : minor_q;
  assign offset_cur = req_i.new_request ? '0 : offset_q;

  // Next-state and result decode for one byte. Fixed-byte checks fall to
  // the error state on mismatch; the error state holds until new_request.
  always_comb begin
    state_d = state_cur;
    minor_d = minor_cur;
    role    = ROLE_DELIM;
    status  = STAT_BUSY;
    unique case (state_cur)
      ST_METHOD: begin
        if (b == ChG || b == ChE || b == ChT) begin
          role = ROLE_METHOD;
        end else if (b == ChSpace) begin
          state_d = ST_URI_FIRST;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_URI_FIRST: begin
        role    = ROLE_URI;
        state_d = ST_URI;
      end
      ST_URI: begin
        if (b == ChSpace) begin
          state_d = ST_VER_H;
        end else begin
          role = ROLE_URI;
        end
      end
      ST_VER_H:     state_d = (b == ChH)     ? ST_VER_T1    : ST_ERROR;
      ST_VER_T1:    state_d = (b == ChT)     ? ST_VER_T2    : ST_ERROR;
      ST_VER_T2:    state_d = (b == ChT)     ? ST_VER_P     : ST_ERROR;
      ST_VER_P:     state_d = (b == ChP)     ? ST_VER_SLASH : ST_ERROR;
      ST_VER_SLASH: state_d = (b == ChSlash) ? ST_VER_MAJOR : ST_ERROR;
      ST_VER_MAJOR: state_d = (b == ChOne)   ? ST_VER_DOT   : ST_ERROR;
      ST_VER_DOT:   state_d = (b == ChDot)   ? ST_VER_MINOR : ST_ERROR;
      ST_VER_MINOR: begin
        if (b == ChOne) begin
          minor_d = 1'b1;
          state_d = ST_VER_CR;
        end else if (b == ChZero) begin
          minor_d = 1'b0;
          state_d = ST_VER_CR;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_VER_CR: state_d = (b == ChCr) ? ST_RL_LF : ST_ERROR;
      ST_RL_LF: begin
        if (b == ChLf) begin
          state_d = ST_LINE_START;
          status  = STAT_LINE;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_LINE_START: begin
        if (b == ChCr) begin
          state_d = ST_END_LF;
        end else begin
          role    = ROLE_KEY;
          state_d = ST_KEY;
        end
      end
      ST_KEY: begin
        if (b == ChColon) begin
          state_d = ST_COLON_SP;
        end else begin
          role = ROLE_KEY;
        end
      end
      ST_COLON_SP: state_d = (b == ChSpace) ? ST_VAL_FIRST : ST_ERROR;
      ST_VAL_FIRST: begin
        role    = ROLE_VALUE;
        state_d = ST_VALUE;
      end
      ST_VALUE: begin
        if (b == ChCr) begin
          state_d = ST_HL_LF;
        end else begin
          role = ROLE_VALUE;
        end
      end
      ST_HL_LF: begin
        if (b == ChLf) begin
          state_d = ST_LINE_START;
          status  = STAT_HEADER;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_END_LF: begin
        if (b == ChLf) begin
          state_d = ST_DONE;
          status  = STAT_DONE;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_DONE: status = STAT_IGNORED;
      default: state_d = ST_ERROR;
    endcase
    // Any byte that lands in (or stays in) the error state reports an error.
    if (state_d == ST_ERROR) begin
      status = STAT_ERROR;
    end
  end

  // The offset saturates at its all-ones value.
  assign offset_d    = (offset_cur == OffsetMax) ? offset_cur
                                                 : offset_cur + OFFSET_BITS'(1);
  assign offset_wide = 32'(offset_cur);

  always_comb begin
    res_d.role   = role;
    res_d.status = status;
    res_d.minor  = minor_d;
    res_d.offset = offset_wide[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_METHOD;
      minor_q    <= 1'b0;
      offset_q   <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        state_q  <= state_d;
        minor_q  <= minor_d;
        offset_q <= offset_d;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (take) begin
        out_vld_q <= skid_vld_q;
      end
      if (skid_load) begin
        skid_vld_q <= 1'b1;
      end else if (take) begin
        skid_vld_q <= 1'b0;
      end
    end
  end

  // Result payload; the skid entry moves forward when the result is taken.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_d;
    end else if (take && skid_vld_q) begin
      out_q <= skid_q;
    end
    if (skid_load) begin
      skid_q <= res_d;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.byte_role   = out_q.role;
  assign res_o.status      = out_q.status;
  assign res_o.http_minor  = out_q.minor;
  assign res_o.byte_offset = out_q.offset;

  `HRHP_ASSERT(a_skid_behind_out, !skid_vld_q || out_vld_q,
               "skid entry valid while result register empty")
  `HRHP_ASSERT(a_stall_only_full, req_i.ready || (out_vld_q && skid_vld_q),
               "input stalled while output buffer has room")
  `HRHP_ASSERT_NEXT(a_error_latch,
                    state_q == ST_ERROR && !(acc && req_i.new_request),
                    state_q == ST_ERROR, "error state left without a new request")
  `HRHP_ASSERT_NEXT(a_offset_sat,
                    offset_q == OffsetMax && !(acc && req_i.new_request),
                    offset_q == OffsetMax, "saturated offset moved")

endmodule

`default_nettype wire

@@ sim/hrhp_result_checker.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser result checker
// Watches both channels, predicts the result of every accepted byte and
// compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hrhp_result_checker
  import hrhp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrhp_in_if          req_i,
  hrhp_out_if         res_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);

  state_e                 model_state;
  logic                   seen_minor;
  logic [OFFSET_BITS-1:0] byte_count;
  result_t                predicted_q[$];
  int unsigned            err_cnt;

  assign err_cnt_o = err_cnt;

  // Advances the parser copy by one byte and returns the result it gives.
  function automatic result_t parse_byte(input logic [7:0] b, input logic restart);
    result_t r;
    state_e  nxt;
    role_e   role;
    status_e stat;
    if (restart) begin
      model_state = ST_METHOD;
      seen_minor  = 1'b0;
      byte_count  = '0;
    end
    role     = ROLE_DELIM;
    stat     = STAT_BUSY;
    nxt      = model_state;
    r.offset = 16'(byte_count);
    case (model_state)
      ST_METHOD: begin
        if (b == ChG || b == ChE || b == ChT) role = ROLE_METHOD;
        else if (b == ChSpace) nxt = ST_URI_FIRST;
        else nxt = ST_ERROR;
      end
      ST_URI_FIRST: begin
        role = ROLE_URI;
        nxt  = ST_URI;
      end
      ST_URI: begin
        if (b == ChSpace) nxt = ST_VER_H;
        else role = ROLE_URI;
      end
      ST_VER_H:     nxt = (b == ChH) ? ST_VER_T1 : ST_ERROR;
      ST_VER_T1:    nxt = (b == ChT) ? ST_VER_T2 : ST_ERROR;
      ST_VER_T2:    nxt = (b == ChT) ? ST_VER_P : ST_ERROR;
      ST_VER_P:     nxt = (b == ChP) ? ST_VER_SLASH : ST_ERROR;
      ST_VER_SLASH: nxt = (b == ChSlash) ? ST_VER_MAJOR : ST_ERROR;
      ST_VER_MAJOR: nxt = (b == ChOne) ? ST_VER_DOT : ST_ERROR;
      ST_VER_DOT:   nxt = (b == ChDot) ? ST_VER_MINOR : ST_ERROR;
      ST_VER_MINOR: begin
        if (b == ChOne || b == ChZero) begin
          seen_minor = (b == ChOne);
          nxt        = ST_VER_CR;
        end else begin
          nxt = ST_ERROR;
        end
      end
      ST_VER_CR: nxt = (b == ChCr) ? ST_RL_LF : ST_ERROR;
      ST_RL_LF: begin
        nxt = (b == ChLf) ? ST_LINE_START : ST_ERROR;
        if (b == ChLf) stat = STAT_LINE;
      end
      ST_LINE_START: begin
        if (b == ChCr) begin
          nxt = ST_END_LF;
        end else begin
          role = ROLE_KEY;
          nxt  = ST_KEY;
        end
      end
      ST_KEY: begin
        if (b == ChColon) nxt = ST_COLON_SP;
        else role = ROLE_KEY;
      end
      ST_COLON_SP: nxt = (b == ChSpace) ? ST_VAL_FIRST : ST_ERROR;
      ST_VAL_FIRST: begin
        role = ROLE_VALUE;
        nxt  = ST_VALUE;
      end
      ST_VALUE: begin
        if (b == ChCr) nxt = ST_HL_LF;
        else role = ROLE_VALUE;
      end
      ST_HL_LF: begin
        nxt = (b == ChLf) ? ST_LINE_START : ST_ERROR;
        if (b == ChLf) stat = STAT_HEADER;
      end
      ST_END_LF: begin
        nxt = (b == ChLf) ? ST_DONE : ST_ERROR;
        if (b == ChLf) stat = STAT_DONE;
      end
      ST_DONE: stat = STAT_IGNORED;
      default: nxt = ST_ERROR;
    endcase
    // Any path into the error state reports it, and the latch keeps reporting.
    if (nxt == ST_ERROR) stat = STAT_ERROR;
    model_state = nxt;
    if (byte_count != '1) byte_count = byte_count + OFFSET_BITS'(1);
    r.role   = role;
    r.status = stat;
    r.minor  = seen_minor;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    if (!rst_ni) begin
      model_state = ST_METHOD;
      seen_minor  = 1'b0;
      byte_count  = '0;
      predicted_q.delete();
      err_cnt   = 0;
      pending_o <= 0;
    end else begin
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        predicted_q.push_back(parse_byte(req_i.data_byte, req_i.new_request));
      end
      if (res_i.valid === 1'b1 && res_i.ready === 1'b1) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: unexpected result, role %0d status %0d offset %0d", $time,
                   res_i.byte_role, res_i.status, res_i.byte_offset);
          err_cnt++;
        end else begin
          want = predicted_q.pop_front();
          if (res_i.byte_role !== want.role) begin
            $display("%0t: byte_role expected %0d, actual %0d (offset %0d)", $time,
                     want.role, res_i.byte_role, want.offset);
            err_cnt++;
          end
          if (res_i.status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d (offset %0d)", $time,
                     want.status, res_i.status, want.offset);
            err_cnt++;
          end
          if (res_i.http_minor !== want.minor) begin
            $display("%0t: http_minor expected %0d, actual %0d (offset %0d)", $time,
                     want.minor, res_i.http_minor, want.offset);
            err_cnt++;
          end
          if (res_i.byte_offset !== want.offset) begin
            $display("%0t: byte_offset expected %0d, actual %0d", $time,
                     want.offset, res_i.byte_offset);
            err_cnt++;
          end
        end
      end
      pending_o <= predicted_q.size();
    end
  end

endmodule

@@ sim/http_request_head_parser_tb.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser testbench
// Feeds the parser directed and random request heads, well formed and broken,
// with random gaps and output stalls, and lets the checker compare results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module http_request_head_parser_tb
  import hrhp_pkg::*;
();

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned RandItems  = 1000;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  bit          no_idle = 1'b0;
  int unsigned err_cnt;
  int unsigned pending;
  int unsigned idle_cycles;
  logic [7:0]  stream_q[$];

  hrhp_in_if  in_if();
  hrhp_out_if out_if();

  always #4 clk = ~clk;

  http_request_head_parser #(.OFFSET_BITS(OffsetBits)) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (in_if),
    .res_o  (out_if)
  );

  hrhp_result_checker #(.OFFSET_BITS(OffsetBits)) u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (in_if),
    .res_i     (out_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  // Result side: a random stall before each result, none while no_idle is set.
  // Ready is only lowered when a stall is actually drawn, so it never gets two
  // updates in one time step.
  always begin : result_sink
    int unsigned stall;
    stall = no_idle ? 0 : $urandom_range(0, 9);
    if (stall != 0) begin
      out_if.ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    out_if.ready <= 1'b1;
    do @(posedge clk); while (out_if.valid !== 1'b1);
  end

  // Watchdog: any stretch without a request moving on either channel that
  // lasts too long means the parser has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("http_request_head_parser_tb: done, errors");
      $finish;
    end
  end

  // Sends one request after a random gap. Valid stays high across back-to-back
  // requests and is only dropped when a gap is drawn.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.new_request <= restart;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  // Sends the buffered head; its first byte restarts the parser.
  task automatic send_stream();
    foreach (stream_q[i]) send_byte(stream_q[i], i == 0);
  endtask

  // Holds the input off until every outstanding result has come back. The wait
  // runs on the clock first, so valid is never lowered and raised in one step.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_but(input logic [7:0] excl);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == excl) ? ~excl : b;
  endfunction

  function automatic logic [7:0] method_letter();
    case ($urandom_range(0, 2))
      0:       return ChG;
      1:       return ChE;
      default: return ChT;
    endcase
  endfunction

  // Builds a well formed head with random content: method letters, URI,
  // version, a few headers and the closing blank line.
  function automatic void build_head();
    int unsigned n;
    stream_q.delete();
    n = $urandom_range(0, 4);
    repeat (n) stream_q.push_back(method_letter());
    stream_q.push_back(ChSpace);
    // The first URI byte is taken whatever it is.
    stream_q.push_back(8'($urandom_range(0, 255)));
    n = $urandom_range(0, 7);
    repeat (n) stream_q.push_back(any_but(ChSpace));
    stream_q.push_back(ChSpace);
    push_str("HTTP/1.");
    stream_q.push_back($urandom_range(0, 1) ? ChOne : ChZero);
    stream_q.push_back(ChCr);
    stream_q.push_back(ChLf);
    repeat ($urandom_range(0, 3)) begin
      stream_q.push_back(any_but(ChCr));
      n = $urandom_range(0, 5);
      repeat (n) stream_q.push_back(any_but(ChColon));
      stream_q.push_back(ChColon);
      stream_q.push_back(ChSpace);
      stream_q.push_back(8'($urandom_range(0, 255)));
      n = $urandom_range(0, 6);
      repeat (n) stream_q.push_back(any_but(ChCr));
      stream_q.push_back(ChCr);
      stream_q.push_back(ChLf);
    end
    stream_q.push_back(ChCr);
    stream_q.push_back(ChLf);
  endfunction

  // Breaks a well formed head: one corrupted byte, or a cut somewhere inside.
  function automatic void damage_head();
    int unsigned idx;
    idx = $urandom_range(1, stream_q.size() - 1);
    if ($urandom_range(0, 1)) begin
      stream_q[idx] = 8'($urandom_range(0, 255));
    end else begin
      while (stream_q.size() > idx) void'(stream_q.pop_back());
    end
  endfunction

  initial begin : stimulus
    int unsigned rand_items;
    int unsigned kind;
    in_if.valid       <= 1'b0;
    in_if.data_byte   <= 8'h00;
    in_if.new_request <= 1'b0;
    rand_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed head: empty method, a space as the first URI byte, a 0xFF URI
    // byte, a colon as the first key byte and CR as the first value byte,
    // then the end of the head and one ignored byte after it.
    stream_q.delete();
    stream_q.push_back(ChSpace);
    stream_q.push_back(ChSpace);
    stream_q.push_back(8'hFF);
    stream_q.push_back(ChSpace);
    push_str("HTTP/1.0");
    stream_q.push_back(ChCr);
    stream_q.push_back(ChLf);
    stream_q.push_back(ChColon);
    stream_q.push_back(ChColon);
    stream_q.push_back(ChSpace);
    stream_q.push_back(ChCr);
    stream_q.push_back(ChCr);
    stream_q.push_back(ChLf);
    stream_q.push_back(ChCr);
    stream_q.push_back(ChLf);
    stream_q.push_back(8'h00);
    send_stream();
    // A bad method byte latches the error; a valid letter afterwards stays in it.
    stream_q.delete();
    stream_q.push_back(8'h00);
    stream_q.push_back(ChG);
    send_stream();
    drain_results();

    // Random heads: mostly well formed, the rest broken or plain noise.
    while (rand_items < RandItems) begin
      no_idle = ($urandom_range(0, 4) == 0);
      kind    = $urandom_range(0, 9);
      if (kind < 7) begin
        build_head();
        send_stream();
        rand_items += stream_q.size();
        // A few bytes past the end of the head are merely ignored.
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 9) begin
        build_head();
        damage_head();
        send_stream();
        rand_items += stream_q.size();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          rand_items++;
        end
      end
      if ($urandom_range(0, 11) == 0) drain_results();
    end

    no_idle = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && pending == 0) begin
      $display("http_request_head_parser_tb: done, clean");
    end else begin
      $display("http_request_head_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
